[rtl/dsat_pkg.sv]
// ----------------------------------------------------------------------------
// dsat_pkg
// Shared types and constants for the graph coloring unit.
// ----------------------------------------------------------------------------
package dsat_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VERT_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_EDGE  = 2'd1;
  localparam logic [1:0] REQ_RUN   = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] vertex_a;
    logic [5:0] vertex_b;
  } in_item_t;

  typedef struct packed {
    logic [5:0] order_index;
    logic [5:0] vertex_id;
    logic [6:0] color;
    logic [6:0] max_color;
    logic       last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_EDGE_RD,
    ST_EDGE_WR,
    ST_DEG_RD,
    ST_DEG_PC,
    ST_DEG_WR,
    ST_SCAN_RD,
    ST_SCAN_PC,
    ST_SCAN_CMP,
    ST_COL_RD,
    ST_COL_FIND,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_EMIT
  } state_t;

endpackage

[rtl/dsatur_graph_coloring_unit.sv]
// ----------------------------------------------------------------------------
// dsatur_graph_coloring_unit
// DSATUR graph coloring over an adjacency matrix held in RAM.
// ----------------------------------------------------------------------------
// One request is taken per start pulse while busy is low. A clear zeroes the
// adjacency RAM one row per cycle, all 64 rows; the same pass runs after
// reset with busy high. An edge add does a read-modify-write of both rows;
// a rejected edge or an unused code finishes at once. A run first sets up
// the degree of each vertex (read, count, write) and then, per selection,
// scans the vertices (read, count and compare for each uncolored one),
// searches for the first free color, updates each uncolored neighbour
// (read, write) and emits the result, all paced by one RAM read per step
// and the one shared population counter. Each result is on out_item with
// out_valid for one cycle; the receiver cannot stall it, and busy falls as
// the last result appears.
module dsatur_graph_coloring_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  dsat_pkg::in_item_t  in_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_vertex_count,
  output logic                out_valid,
  output dsat_pkg::out_item_t out_item
);

  localparam int NV = dsat_pkg::MAX_VERTICES;
  localparam int AW = dsat_pkg::VERT_W;
  localparam int CW = dsat_pkg::CNT_W;

  dsat_pkg::state_t state_r, state_nxt;

  logic [6:0]          vcount_r;
  logic [CW-1:0]       n_eff;
  logic [AW-1:0]       a_r, b_r;
  logic                edge_ph_r, edge_ph_nxt;
  logic [CW-1:0]       i_r, i_nxt;
  logic [CW-1:0]       k_r;
  logic [AW-1:0]       pick_r;
  logic                found_r;
  logic [CW-1:0]       bsat_r, bconn_r, bdeg_r;
  logic [CW-1:0]       col_r, maxc_r;
  logic [NV-1:0]       colored_r;
  logic [NV-1:0]       prow_r;
  logic [NV-1:0]       rowmask;
  logic                out_valid_r;
  dsat_pkg::out_item_t out_r;

  logic          adj_we;
  logic [AW-1:0] adj_wa, adj_ra;
  logic [NV-1:0] adj_wd, adj_rd;
  logic          blk_we;
  logic [AW-1:0] blk_wa, blk_ra;
  logic [NV-1:0] blk_wd, blk_rd;
  logic          cnt_we;
  logic [AW-1:0] cnt_wa, cnt_ra;
  logic [2*CW-1:0] cnt_wd, cnt_rd;

  logic [NV-1:0] pc_row;
  logic [CW-1:0] pc_cnt;

  logic [AW-1:0] idx;
  logic          last_i;
  logic          edge_ok;
  logic [AW-1:0] edge_row, edge_col;
  logic [AW-1:0] first_free;
  logic          ff_found;
  logic [CW-1:0] col_new;
  logic          cand_better;
  logic [CW-1:0] c_conn, c_deg;

  dsat_ram #(.WIDTH(NV), .DEPTH(NV)) u_adj (
    .clk, .we(adj_we), .waddr(adj_wa), .wdata(adj_wd), .raddr(adj_ra), .rdata(adj_rd));
  dsat_ram #(.WIDTH(NV), .DEPTH(NV)) u_blk (
    .clk, .we(blk_we), .waddr(blk_wa), .wdata(blk_wd), .raddr(blk_ra), .rdata(blk_rd));
  dsat_ram #(.WIDTH(2*CW), .DEPTH(NV)) u_cnt (
    .clk, .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd), .raddr(cnt_ra), .rdata(cnt_rd));

  dsat_popcnt #(.W(NV)) u_pc (.clk, .row(pc_row), .count_r(pc_cnt));

  always_comb begin
    if (vcount_r == 7'd0) begin
      n_eff = CW'(1);
    end else if (vcount_r > 7'(NV)) begin
      n_eff = CW'(NV);
    end else begin
      n_eff = CW'(vcount_r);
    end
  end

  always_comb begin
    for (int j = 0; j < NV; j++) begin
      rowmask[j] = (CW'(j) < n_eff);
    end
  end

  assign busy      = (state_r != dsat_pkg::ST_IDLE);
  assign cfg_ready = !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign idx      = i_r[AW-1:0];
  assign last_i   = (i_r + CW'(1) >= n_eff);
  assign c_conn   = cnt_rd[2*CW-1:CW];
  assign c_deg    = cnt_rd[CW-1:0];
  assign edge_row = edge_ph_r ? b_r : a_r;
  assign edge_col = edge_ph_r ? a_r : b_r;
  assign pc_row   = (state_r == dsat_pkg::ST_DEG_PC) ? (adj_rd & rowmask) : blk_rd;
  assign edge_ok  = (in_item.vertex_a != in_item.vertex_b) &&
                    (CW'(in_item.vertex_a) < n_eff) && (CW'(in_item.vertex_b) < n_eff);

  always_comb begin
    first_free = '0;
    ff_found   = 1'b0;
    for (int c = NV - 1; c >= 0; c--) begin
      if (!blk_rd[c]) begin
        first_free = AW'(c);
        ff_found   = 1'b1;
      end
    end
  end

  assign col_new = (ff_found && (CW'(first_free) + CW'(1) < n_eff)) ?
                   CW'(first_free) + CW'(1) : n_eff;

  always_comb begin
    cand_better = 1'b0;
    if (!found_r) begin
      cand_better = 1'b1;
    end else if (k_r == '0) begin
      cand_better = c_deg > bdeg_r;
    end else if (pc_cnt > bsat_r) begin
      cand_better = 1'b1;
    end else if (pc_cnt == bsat_r && c_conn > bconn_r) begin
      cand_better = 1'b1;
    end else if (pc_cnt == bsat_r && c_conn == bconn_r && c_deg > bdeg_r) begin
      cand_better = 1'b1;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    i_nxt       = i_r;
    edge_ph_nxt = edge_ph_r;
    adj_we = 1'b0; adj_wa = idx; adj_wd = '0; adj_ra = idx;
    blk_we = 1'b0; blk_wa = idx; blk_wd = '0; blk_ra = idx;
    cnt_we = 1'b0; cnt_wa = idx; cnt_wd = '0; cnt_ra = idx;
    unique case (state_r)
      dsat_pkg::ST_IDLE: begin
        if (start) begin
          i_nxt       = '0;
          edge_ph_nxt = 1'b0;
          unique case (in_item.req_type)
            dsat_pkg::REQ_CLEAR: state_nxt = dsat_pkg::ST_CLR;
            dsat_pkg::REQ_EDGE: begin
              if (edge_ok) state_nxt = dsat_pkg::ST_EDGE_RD;
            end
            dsat_pkg::REQ_RUN:   state_nxt = dsat_pkg::ST_DEG_RD;
            default: ;
          endcase
        end
      end
      dsat_pkg::ST_CLR: begin
        adj_we = 1'b1;
        i_nxt  = i_r + CW'(1);
        if (i_r == CW'(NV - 1)) begin
          i_nxt     = '0;
          state_nxt = dsat_pkg::ST_IDLE;
        end
      end
      dsat_pkg::ST_EDGE_RD: begin
        adj_ra    = edge_row;
        state_nxt = dsat_pkg::ST_EDGE_WR;
      end
      dsat_pkg::ST_EDGE_WR: begin
        adj_we = 1'b1;
        adj_wa = edge_row;
        adj_wd = adj_rd;
        adj_wd[edge_col] = 1'b1;
        if (edge_ph_r) begin
          state_nxt = dsat_pkg::ST_IDLE;
        end else begin
          edge_ph_nxt = 1'b1;
          state_nxt   = dsat_pkg::ST_EDGE_RD;
        end
      end
      dsat_pkg::ST_DEG_RD: begin
        state_nxt = dsat_pkg::ST_DEG_PC;
      end
      dsat_pkg::ST_DEG_PC: begin
        state_nxt = dsat_pkg::ST_DEG_WR;
      end
      dsat_pkg::ST_DEG_WR: begin
        cnt_we = 1'b1;
        cnt_wd = {CW'(0), pc_cnt};
        blk_we = 1'b1;
        if (last_i) begin
          i_nxt     = '0;
          state_nxt = dsat_pkg::ST_SCAN_RD;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = dsat_pkg::ST_DEG_RD;
        end
      end
      dsat_pkg::ST_SCAN_RD: begin
        if (!colored_r[idx]) begin
          state_nxt = dsat_pkg::ST_SCAN_PC;
        end else if (last_i) begin
          i_nxt     = '0;
          state_nxt = dsat_pkg::ST_COL_RD;
        end else begin
          i_nxt = i_r + CW'(1);
        end
      end
      dsat_pkg::ST_SCAN_PC: begin
        state_nxt = dsat_pkg::ST_SCAN_CMP;
      end
      dsat_pkg::ST_SCAN_CMP: begin
        if (last_i) begin
          i_nxt     = '0;
          state_nxt = dsat_pkg::ST_COL_RD;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = dsat_pkg::ST_SCAN_RD;
        end
      end
      dsat_pkg::ST_COL_RD: begin
        blk_ra    = pick_r;
        adj_ra    = pick_r;
        state_nxt = dsat_pkg::ST_COL_FIND;
      end
      dsat_pkg::ST_COL_FIND: begin
        state_nxt = dsat_pkg::ST_UPD_RD;
      end
      dsat_pkg::ST_UPD_RD: begin
        if (!colored_r[idx] && prow_r[idx]) begin
          state_nxt = dsat_pkg::ST_UPD_WR;
        end else if (last_i) begin
          state_nxt = dsat_pkg::ST_EMIT;
        end else begin
          i_nxt = i_r + CW'(1);
        end
      end
      dsat_pkg::ST_UPD_WR: begin
        blk_we = 1'b1;
        blk_wd = blk_rd;
        blk_wd[AW'(col_r - CW'(1))] = 1'b1;
        cnt_we = 1'b1;
        cnt_wd = {c_conn + CW'(1), (c_deg != '0) ? c_deg - CW'(1) : c_deg};
        if (last_i) begin
          state_nxt = dsat_pkg::ST_EMIT;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = dsat_pkg::ST_UPD_RD;
        end
      end
      dsat_pkg::ST_EMIT: begin
        i_nxt = '0;
        if (k_r + CW'(1) >= n_eff) begin
          state_nxt = dsat_pkg::ST_IDLE;
        end else begin
          state_nxt = dsat_pkg::ST_SCAN_RD;
        end
      end
      default: state_nxt = dsat_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= dsat_pkg::ST_CLR;
      i_r       <= '0;
      edge_ph_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      i_r       <= i_nxt;
      edge_ph_r <= edge_ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r    <= 7'd64;
      out_valid_r <= 1'b0;
      out_r       <= '0;
      found_r     <= 1'b0;
      k_r         <= '0;
      maxc_r      <= '0;
      colored_r   <= '0;
    end else begin
      out_valid_r <= (state_r == dsat_pkg::ST_EMIT);
      if (cfg_valid && cfg_ready) vcount_r <= cfg_vertex_count;
      case (state_r)
        dsat_pkg::ST_IDLE: begin
          if (start) begin
            a_r       <= in_item.vertex_a;
            b_r       <= in_item.vertex_b;
            k_r       <= '0;
            maxc_r    <= '0;
            colored_r <= '0;
            found_r   <= 1'b0;
          end
        end
        dsat_pkg::ST_SCAN_CMP: begin
          if (cand_better) begin
            found_r <= 1'b1;
            pick_r  <= idx;
            bsat_r  <= pc_cnt;
            bconn_r <= c_conn;
            bdeg_r  <= c_deg;
          end
        end
        dsat_pkg::ST_COL_FIND: begin
          prow_r <= adj_rd & rowmask;
          col_r  <= col_new;
          if (col_new > maxc_r) maxc_r <= col_new;
          colored_r[pick_r] <= 1'b1;
        end
        dsat_pkg::ST_EMIT: begin
          out_r.order_index <= k_r[AW-1:0];
          out_r.vertex_id   <= pick_r;
          out_r.color       <= col_r;
          out_r.max_color   <= maxc_r;
          out_r.last        <= (k_r + CW'(1) >= n_eff);
          k_r               <= k_r + CW'(1);
          found_r           <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/dsat_ram.sv]
// ----------------------------------------------------------------------------
// dsat_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module dsat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/dsat_popcnt.sv]
// ----------------------------------------------------------------------------
// dsat_popcnt
// Registered population count of one stored row.
// ----------------------------------------------------------------------------
module dsat_popcnt #(
  parameter int W = 64
) (
  input  logic                 clk,
  input  logic [W-1:0]         row,
  output logic [$clog2(W+1)-1:0] count_r
);

  logic [$clog2(W+1)-1:0] count_nxt;

  always_comb begin
    count_nxt = '0;
    for (int i = 0; i < W; i++) begin
      count_nxt = count_nxt + {{($clog2(W+1)-1){1'b0}}, row[i]};
    end
  end

  always_ff @(posedge clk) begin
    count_r <= count_nxt;
  end

endmodule

[tb/sv/dsatur_graph_coloring_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsatur_graph_coloring_unit_test
// Loads random and directed graphs into the coloring unit and runs DSATUR
// on them. Every coloring order and color is predicted in the bench and
// checked field by field against each out_valid item.
// ----------------------------------------------------------------------------
module dsatur_graph_coloring_unit_test;

  localparam int NV = dsat_pkg::MAX_VERTICES;
  localparam int SETTLE = 200;
  localparam longint CYCLE_LIMIT = 64'd4000000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  dsat_pkg::in_item_t in_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [6:0] cfg_vertex_count;
  logic out_valid;
  dsat_pkg::out_item_t out_item;

  dsatur_graph_coloring_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_vertex_count(cfg_vertex_count), .out_valid(out_valid),
    .out_item(out_item)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // bench copy of the graph and register
  logic [NV-1:0] adj_rows [NV];
  logic [6:0] vcount_reg;
  dsat_pkg::out_item_t expected_items[$];
  dsat_pkg::in_item_t pending_items[$];
  int mismatches;
  int sender_idle_pct;
  int cfg_pending;
  logic [6:0] cfg_value;
  longint cycles;

  function automatic int eff_count();
    if (vcount_reg < 7'd1) return 1;
    if (vcount_reg > NV) return NV;
    return int'(vcount_reg);
  endfunction

  function automatic int ones(logic [NV-1:0] x);
    int c;
    c = 0;
    for (int i = 0; i < NV; i++) c += x[i];
    return c;
  endfunction

  task automatic queue_item(dsat_pkg::in_item_t it);
    pending_items = {pending_items, it};
  endtask

  task automatic color_graph();
    int n;
    logic [NV-1:0] done_mask;
    logic [NV-1:0] blocked [NV];
    int conn [NV];
    int deg [NV];
    int max_col;
    int pick, col, bs, bc, bd, s;
    bit found;
    dsat_pkg::out_item_t r;
    n = eff_count();
    done_mask = '0;
    max_col = 0;
    for (int v = 0; v < NV; v++) begin
      blocked[v] = '0;
      conn[v] = 0;
      deg[v] = 0;
      if (v < n)
        for (int j = 0; j < n; j++)
          if (j != v && adj_rows[v][j]) deg[v]++;
    end
    for (int k = 0; k < n; k++) begin
      pick = 0; found = 0; bs = 0; bc = 0; bd = 0;
      for (int v = 0; v < n; v++) begin
        if (done_mask[v]) continue;
        s = ones(blocked[v]);
        if (k == 0) begin
          if (!found || deg[v] > bd) begin
            found = 1; bd = deg[v]; pick = v;
          end
        end else if (!found || s > bs) begin
          found = 1; bs = s; bc = conn[v]; bd = deg[v]; pick = v;
        end else if (s == bs && conn[v] > bc) begin
          bc = conn[v]; bd = deg[v]; pick = v;
        end else if (s == bs && conn[v] == bc && deg[v] > bd) begin
          bd = deg[v]; pick = v;
        end
      end
      col = 1;
      while (col < n && blocked[pick][col-1]) col++;
      done_mask[pick] = 1'b1;
      if (col > max_col) max_col = col;
      for (int j = 0; j < n; j++) begin
        if (done_mask[j]) continue;
        if (adj_rows[pick][j] || adj_rows[j][pick]) begin
          if (deg[j] > 0) deg[j]--;
          conn[j]++;
          blocked[j][col-1] = 1'b1;
        end
      end
      r.order_index = 6'(k);
      r.vertex_id = 6'(pick);
      r.color = 7'(col);
      r.max_color = 7'(max_col);
      r.last = (k + 1 == n);
      expected_items = {expected_items, r};
    end
  endtask

  task automatic apply_request(dsat_pkg::in_item_t it);
    int n;
    n = eff_count();
    case (it.req_type)
      dsat_pkg::REQ_CLEAR: for (int i = 0; i < NV; i++) adj_rows[i] = '0;
      dsat_pkg::REQ_EDGE: begin
        if (it.vertex_a != it.vertex_b && it.vertex_a < n && it.vertex_b < n) begin
          adj_rows[it.vertex_a][it.vertex_b] = 1'b1;
          adj_rows[it.vertex_b][it.vertex_a] = 1'b1;
        end
      end
      dsat_pkg::REQ_RUN: color_graph();
      default: ;
    endcase
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_item <= '0;
    end else if (!(start && !busy) && start) begin
      start <= 1'b1;
    end else begin
      if (start && !busy) apply_request(in_item);
      if (start && !busy && pending_items.size() > 0) pending_items.pop_front();
      if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        start <= 1'b1;
        in_item <= pending_items[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // config writer
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
      cfg_vertex_count <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      vcount_reg = cfg_vertex_count;
      cfg_valid <= 1'b0;
      cfg_pending = 0;
    end else if (cfg_pending == 1 && !cfg_valid) begin
      cfg_valid <= 1'b1;
      cfg_vertex_count <= cfg_value;
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (expected_items.size() == 0) begin
        $display("unexpected item at %0t", $time);
        mismatches++;
      end else begin
        if (out_item.order_index !== expected_items[0].order_index)
          report("order_index", int'(out_item.order_index),
                 int'(expected_items[0].order_index));
        if (out_item.vertex_id !== expected_items[0].vertex_id)
          report("vertex_id", int'(out_item.vertex_id), int'(expected_items[0].vertex_id));
        if (out_item.color !== expected_items[0].color)
          report("color", int'(out_item.color), int'(expected_items[0].color));
        if (out_item.max_color !== expected_items[0].max_color)
          report("max_color", int'(out_item.max_color), int'(expected_items[0].max_color));
        if (out_item.last !== expected_items[0].last)
          report("last", int'(out_item.last), int'(expected_items[0].last));
        expected_items.pop_front();
      end
    end
  end

  function automatic dsat_pkg::in_item_t mk(logic [1:0] t, int a, int b);
    dsat_pkg::in_item_t it;
    it.req_type = t;
    it.vertex_a = 6'(a);
    it.vertex_b = 6'(b);
    return it;
  endfunction

  task automatic drain();
    while (pending_items.size() > 0 || start || busy || expected_items.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_count(int v);
    cfg_value = 7'(v);
    cfg_pending = 1;
    while (cfg_pending) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic random_graph(int nv, int edges);
    queue_item(mk(dsat_pkg::REQ_CLEAR, $urandom, $urandom));
    for (int e = 0; e < edges; e++) begin
      if ($urandom_range(9) == 0)
        queue_item(mk(2'($urandom), $urandom, $urandom));
      else
        queue_item(mk(dsat_pkg::REQ_EDGE, $urandom_range(nv - 1),
                      $urandom_range(nv - 1)));
    end
    queue_item(mk(dsat_pkg::REQ_RUN, $urandom, $urandom));
  endtask

  initial begin
    int nv;
    rst_n = 1'b0;
    cfg_pending = 0;
    cfg_value = 7'd64;
    mismatches = 0;
    cycles = 0;
    sender_idle_pct = 0;
    vcount_reg = 7'd64;
    for (int i = 0; i < NV; i++) adj_rows[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty graph at full size, all-ones endpoints, self-loop,
    // out of range, duplicate, unused code
    queue_item(mk(dsat_pkg::REQ_RUN, 0, 0));
    queue_item(mk(dsat_pkg::REQ_EDGE, 63, 0));
    queue_item(mk(dsat_pkg::REQ_EDGE, 0, 63));
    queue_item(mk(dsat_pkg::REQ_EDGE, 21, 42));
    queue_item(mk(dsat_pkg::REQ_EDGE, 42, 42));
    queue_item(mk(2'd3, 63, 63));
    queue_item(mk(dsat_pkg::REQ_RUN, 63, 63));
    drain();
    write_count(4);
    queue_item(mk(dsat_pkg::REQ_EDGE, 0, 1));
    queue_item(mk(dsat_pkg::REQ_EDGE, 1, 2));
    queue_item(mk(dsat_pkg::REQ_EDGE, 2, 3));
    queue_item(mk(dsat_pkg::REQ_EDGE, 3, 0));
    queue_item(mk(dsat_pkg::REQ_EDGE, 0, 5));
    queue_item(mk(dsat_pkg::REQ_RUN, 0, 0));
    drain();
    write_count(0);
    queue_item(mk(dsat_pkg::REQ_RUN, 0, 0));
    drain();
    write_count(127);
    queue_item(mk(dsat_pkg::REQ_RUN, 0, 0));
    queue_item(mk(dsat_pkg::REQ_CLEAR, 0, 0));
    queue_item(mk(dsat_pkg::REQ_RUN, 0, 0));
    drain();

    // random phases: no idling, sender idle, two graphs in a row, light idling
    for (int ph = 0; ph < 8; ph++) begin
      sender_idle_pct = (ph % 4 == 1) ? 60 : ((ph % 4 == 3) ? 7 : 0);
      nv = (ph == 7) ? 64 : $urandom_range(2, 12);
      write_count(nv + ((ph == 3) ? 3 : 0));
      random_graph(nv, $urandom_range(8, 20));
      if (ph == 2) begin
        drain();
        random_graph(nv, 10);
      end
      drain();
    end
    write_count(1);
    queue_item(mk(dsat_pkg::REQ_RUN, 0, 0));
    drain();

    if (mismatches == 0 && expected_items.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
